// File: sv/swmc_pkg.sv
package swmc_pkg;

  // Default window length and queue depth.
  localparam int WINDOW_SAMPLES = 64;
  localparam int QUEUE_DEPTH    = 4;

  // Code limits of a converter sample.
  localparam logic signed [15:0] CODE_MAX = 16'sh7fff;
  localparam logic signed [15:0] CODE_MIN = 16'sh8000;

  // Item modes.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_ARM    = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  // Measurement kinds; anything from this code up is not capturable.
  localparam logic [1:0] KIND_POWER = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_IGNORED   = 4'd0;
  localparam logic [3:0] ST_DUPLICATE = 4'd1;
  localparam logic [3:0] ST_DISCARDED = 4'd2;
  localparam logic [3:0] ST_ACCUM     = 4'd3;
  localparam logic [3:0] ST_UNSTABLE  = 4'd4;
  localparam logic [3:0] ST_CAPTURED  = 4'd5;
  localparam logic [3:0] ST_ARMED     = 4'd6;
  localparam logic [3:0] ST_BUSY      = 4'd7;
  localparam logic [3:0] ST_INVALID   = 4'd8;
  localparam logic [3:0] ST_CANCELLED = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET_CHANNEL = 3'd0;
  localparam logic [2:0] REG_TARGET_KIND    = 3'd1;
  localparam logic [2:0] REG_TARGET_INPUT   = 3'd2;
  localparam logic [2:0] REG_DISCARD_COUNT  = 3'd3;
  localparam logic [2:0] REG_SPREAD_LIMIT   = 3'd4;

  // One configuration write.
  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_write_t;

  // Classification of one item as the front end decided it.
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] spread;
  } result_t;

endpackage

// File: sv/stable_window_mean_capture.sv
// A taken word enters the 4-entry queue and then the 3-stage mean pipeline.
// Throughput: one word per cycle while the queue has room, set by the
// combinational classify and window update in the front end.
// Reset: synchronous rst clears the capture state, the queue pointers and the
// pipeline valid bits and loads the configuration registers with defaults.
module stable_window_mean_capture #(
  parameter int WINDOW_SAMPLES = swmc_pkg::WINDOW_SAMPLES,
  parameter int QUEUE_DEPTH    = swmc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sample_channel[3:0], sample_kind[5:4], sample_input[9:6],
  // generation_tag[41:10], sample_code[57:42], zero fill[63:58]
  input  logic [63:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mean_code[15:0], window_spread[31:16]
  output logic [31:0] m_tdata,
  // status[3:0]
  output logic [3:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SUM_W = 16 + $clog2(WINDOW_SAMPLES) + 1;
  localparam int RES_W = $bits(swmc_pkg::result_t);
  localparam int Q_W   = SUM_W + RES_W;

  swmc_pkg::cfg_write_t    cfg;
  swmc_pkg::result_t       push_res;
  swmc_pkg::result_t       pop_res;
  logic signed [SUM_W-1:0] push_sum;
  logic signed [SUM_W-1:0] pop_sum;
  logic                    push, pop, full, empty;
  logic [Q_W-1:0]          pop_data;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  swmc_front #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .SUM_W          (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (s_tuser),
    .in_word    (s_tdata),
    .queue_full (full),
    .push       (push),
    .push_res   (push_res),
    .push_sum   (push_sum)
  );

  swmc_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_res}),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Split a queue entry back into its classification and window sum.
  assign pop_res = pop_data[RES_W-1:0];
  assign pop_sum = pop_data[Q_W-1:RES_W];

  swmc_back #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .SUM_W          (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop        (pop),
    .pop_res    (pop_res),
    .pop_sum    (pop_sum),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_word   (m_tdata)
  );

endmodule

// File: sv/swmc_front.sv
module swmc_front #(
  parameter int WINDOW_SAMPLES = swmc_pkg::WINDOW_SAMPLES,
  parameter int SUM_W          = 16 + $clog2(WINDOW_SAMPLES) + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swmc_pkg::cfg_write_t    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic [63:0]             in_word,
  input  logic                    queue_full,
  output logic                    push,
  output swmc_pkg::result_t       push_res,
  output logic signed [SUM_W-1:0] push_sum
);

  localparam int COUNT_W = $clog2(WINDOW_SAMPLES + 1);

  // Configuration registers.
  logic [3:0]  target_channel;
  logic [1:0]  target_kind;
  logic [3:0]  target_input;
  logic [7:0]  discard_count;
  logic [15:0] spread_limit;

  // Capture state.
  logic                    active, active_next;
  logic [7:0]              discard_left, discard_left_next;
  logic [COUNT_W-1:0]      window_count, window_count_next;
  logic signed [15:0]      window_min, window_min_next;
  logic signed [15:0]      window_max, window_max_next;
  logic signed [SUM_W-1:0] window_sum, window_sum_next;
  logic [31:0]             last_gen, last_gen_next;

  // Input word fields.
  logic [3:0]         sample_channel;
  logic [1:0]         sample_kind;
  logic [3:0]         sample_input;
  logic [31:0]        generation_tag;
  logic signed [15:0] sample_code;

  // Per-sample window arithmetic.
  logic                    match;
  logic signed [15:0]      cand_min, cand_max;
  logic signed [16:0]      cand_diff;
  logic [15:0]             cand_spread;
  logic signed [SUM_W-1:0] cand_sum;
  logic [COUNT_W-1:0]      cand_count;

  assign sample_channel = in_word[3:0];
  assign sample_kind    = in_word[5:4];
  assign sample_input   = in_word[9:6];
  assign generation_tag = in_word[41:10];
  assign sample_code    = in_word[57:42];

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_channel <= 4'd0;
      target_kind    <= 2'd0;
      target_input   <= 4'd1;
      discard_count  <= 8'd4;
      spread_limit   <= 16'd8;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        swmc_pkg::REG_TARGET_CHANNEL: target_channel <= cfg.data[3:0];
        swmc_pkg::REG_TARGET_KIND:    target_kind    <= cfg.data[1:0];
        swmc_pkg::REG_TARGET_INPUT:   target_input   <= cfg.data[3:0];
        swmc_pkg::REG_DISCARD_COUNT:  discard_count  <= cfg.data[7:0];
        swmc_pkg::REG_SPREAD_LIMIT:   spread_limit   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Window candidates with the current sample folded in.
  assign match = (in_mode == swmc_pkg::MODE_SAMPLE) && (sample_kind < swmc_pkg::KIND_POWER) &&
                 active && (sample_channel == target_channel) &&
                 (sample_kind == target_kind) && (sample_input == target_input);
  assign cand_min    = (sample_code < window_min) ? sample_code : window_min;
  assign cand_max    = (sample_code > window_max) ? sample_code : window_max;
  assign cand_diff   = {cand_max[15], cand_max} - {cand_min[15], cand_min};
  assign cand_spread = cand_diff[15:0];
  assign cand_sum    = window_sum + SUM_W'(sample_code);
  assign cand_count  = window_count + COUNT_W'(1);

  // Classify the item and work out the next state.
  always_comb begin
    active_next       = active;
    discard_left_next = discard_left;
    window_count_next = window_count;
    window_min_next   = window_min;
    window_max_next   = window_max;
    window_sum_next   = window_sum;
    last_gen_next     = last_gen;
    push_res.status   = swmc_pkg::ST_IGNORED;
    push_res.spread   = 16'd0;
    push_sum          = cand_sum;
    unique case (in_mode)
      swmc_pkg::MODE_ARM: begin
        if (target_kind >= swmc_pkg::KIND_POWER || target_input == 4'd0) begin
          push_res.status = swmc_pkg::ST_INVALID;
        end else if (active) begin
          push_res.status = swmc_pkg::ST_BUSY;
        end else begin
          active_next       = 1'b1;
          last_gen_next     = 32'd0;
          discard_left_next = discard_count;
          window_count_next = '0;
          window_min_next   = swmc_pkg::CODE_MAX;
          window_max_next   = swmc_pkg::CODE_MIN;
          window_sum_next   = '0;
          push_res.status   = swmc_pkg::ST_ARMED;
        end
      end
      swmc_pkg::MODE_CANCEL: begin
        active_next     = 1'b0;
        push_res.status = swmc_pkg::ST_CANCELLED;
      end
      swmc_pkg::MODE_SAMPLE: begin
        if (match) begin
          if (generation_tag != 32'd0 && generation_tag == last_gen) begin
            push_res.status = swmc_pkg::ST_DUPLICATE;
          end else begin
            last_gen_next = generation_tag;
            if (discard_left != 8'd0) begin
              discard_left_next = discard_left - 8'd1;
              push_res.status   = swmc_pkg::ST_DISCARDED;
            end else if (cand_count == COUNT_W'(WINDOW_SAMPLES)) begin
              push_res.spread = cand_spread;
              if (cand_spread <= spread_limit) begin
                active_next       = 1'b0;
                window_min_next   = cand_min;
                window_max_next   = cand_max;
                window_sum_next   = cand_sum;
                window_count_next = cand_count;
                push_res.status   = swmc_pkg::ST_CAPTURED;
              end else begin
                discard_left_next = discard_count;
                window_count_next = '0;
                window_min_next   = swmc_pkg::CODE_MAX;
                window_max_next   = swmc_pkg::CODE_MIN;
                window_sum_next   = '0;
                push_res.status   = swmc_pkg::ST_UNSTABLE;
              end
            end else begin
              window_min_next   = cand_min;
              window_max_next   = cand_max;
              window_sum_next   = cand_sum;
              window_count_next = cand_count;
              push_res.status   = swmc_pkg::ST_ACCUM;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // State registers move only when an item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      discard_left <= 8'd0;
      window_count <= '0;
      window_min   <= swmc_pkg::CODE_MAX;
      window_max   <= swmc_pkg::CODE_MIN;
      window_sum   <= '0;
      last_gen     <= 32'd0;
    end else if (push) begin
      active       <= active_next;
      discard_left <= discard_left_next;
      window_count <= window_count_next;
      window_min   <= window_min_next;
      window_max   <= window_max_next;
      window_sum   <= window_sum_next;
      last_gen     <= last_gen_next;
    end
  end

`ifndef SYNTH
  // A running capture never holds a full window.
  a_count_below_window: assert property (@(posedge clk) disable iff (rst)
    active |-> (window_count < COUNT_W'(WINDOW_SAMPLES)))
    else $error("window count reached the window length while running");

  // A capture result ends the capture.
  a_capture_ends: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.status == swmc_pkg::ST_CAPTURED) |=> !active)
    else $error("capture still running after a captured result");

  // An accepted arm starts from an empty window and a cleared tag.
  a_arm_clears: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.status == swmc_pkg::ST_ARMED) |=>
      (active && window_count == '0 && last_gen == 32'd0 && window_sum == '0))
    else $error("arm did not start a clean capture");
`endif

endmodule

// File: sv/swmc_queue.sv
module swmc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = swmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[head];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/swmc_back.sv
module swmc_back #(
  parameter int WINDOW_SAMPLES = swmc_pkg::WINDOW_SAMPLES,
  parameter int SUM_W          = 16 + $clog2(WINDOW_SAMPLES) + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  output logic                    pop,
  input  swmc_pkg::result_t       pop_res,
  input  logic signed [SUM_W-1:0] pop_sum,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0]              out_status,
  output logic [31:0]             out_word
);

  // Rounding magnitude, reciprocal of the window length and its scale.
  localparam int             A_W    = SUM_W;
  localparam logic [A_W:0]   RECIP  = (A_W + 1)'((64'd1 << A_W) / WINDOW_SAMPLES);
  localparam logic [A_W-1:0] HALF   = A_W'(WINDOW_SAMPLES / 2);
  localparam logic [A_W-1:0] WLEN   = A_W'(WINDOW_SAMPLES);

  logic advance;

  // Stage one: sign and rounded magnitude.
  logic              s1_valid;
  swmc_pkg::result_t s1_res;
  logic              s1_neg;
  logic [A_W-1:0]    s1_mag;

  // Stage two: quotient estimate from the reciprocal.
  logic              s2_valid;
  swmc_pkg::result_t s2_res;
  logic              s2_neg;
  logic [A_W-1:0]    s2_mag;
  logic [16:0]       s2_quot;

  logic [2*A_W:0]    prod;
  logic [A_W-1:0]    back_mul;
  logic [A_W-1:0]    remainder;
  logic [16:0]       quot;
  logic [15:0]       mean;

  // The whole line moves whenever the output word is free or taken.
  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  assign prod      = (2 * A_W + 1)'(s1_mag) * (2 * A_W + 1)'(RECIP);
  assign back_mul  = A_W'(s2_quot) * WLEN;
  assign remainder = s2_mag - back_mul;
  assign quot      = (remainder >= WLEN) ? s2_quot + 17'd1 : s2_quot;
  assign mean      = s2_neg ? 16'(~quot + 17'd1) : quot[15:0];

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_res  <= pop_res;
      s1_neg  <= pop_sum[SUM_W-1];
      s1_mag  <= (pop_sum[SUM_W-1] ? A_W'(-pop_sum) : A_W'(pop_sum)) + HALF;
      s2_res  <= s1_res;
      s2_neg  <= s1_neg;
      s2_mag  <= s1_mag;
      s2_quot <= 17'(prod[2*A_W:A_W]);
      out_status      <= s2_res.status;
      out_word[31:16] <= s2_res.spread;
      out_word[15:0]  <= (s2_res.status == swmc_pkg::ST_CAPTURED) ? mean : 16'd0;
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [1:0] KIND_VOLTAGE  = 2'd0;
  localparam logic [1:0] KIND_CURRENT  = 2'd1;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam int LATENCY        = 3;
  localparam int MAX_GAP        = 16;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WIN            = swmc_pkg::WINDOW_SAMPLES;

  // One expected result word.
  typedef struct packed {
    logic [3:0]         status;
    logic signed [15:0] mean;
    logic [15:0]        spread;
  } capture_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Configuration as the testbench has written it.
  logic [3:0]  sel_channel;
  logic [1:0]  sel_kind;
  logic [3:0]  sel_input;
  logic [7:0]  discard_setting;
  logic [15:0] spread_setting;

  // Capture state as predicted.
  bit                 cap_active;
  logic [7:0]         discard_left;
  logic [6:0]         win_count;
  logic signed [15:0] win_min;
  logic signed [15:0] win_max;
  logic signed [21:0] win_sum;
  logic [31:0]        last_tag;

  capture_result_t pending_results [$];

  bit tx_gaps;
  bit rx_gaps;
  int errors;
  int items_sent;
  int words_checked;
  int config_writes;
  int status_count [16];

  stable_window_mean_capture i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // Empty the window and reload the discard phase.
  function automatic void restart_window();
    discard_left = discard_setting;
    win_count    = '0;
    win_min      = swmc_pkg::CODE_MAX;
    win_max      = swmc_pkg::CODE_MIN;
    win_sum      = '0;
  endfunction

  // Predicted response of the block to one input word.
  task automatic capture_step(input logic [1:0] mode, input logic [3:0] ch,
                              input logic [1:0] kind, input logic [3:0] inp,
                              input logic [31:0] tag, input logic signed [15:0] code,
                              output capture_result_t r);
    logic signed [16:0] diff;
    int total;
    r = '{swmc_pkg::ST_IGNORED, 16'sd0, 16'd0};
    case (mode)
      swmc_pkg::MODE_ARM: begin
        // A bad target is reported ahead of a running capture.
        if (sel_kind >= swmc_pkg::KIND_POWER || sel_input == 4'd0) begin
          r.status = swmc_pkg::ST_INVALID;
        end else if (cap_active) begin
          r.status = swmc_pkg::ST_BUSY;
        end else begin
          cap_active = 1'b1;
          last_tag   = '0;
          restart_window();
          r.status   = swmc_pkg::ST_ARMED;
        end
      end
      swmc_pkg::MODE_CANCEL: begin
        cap_active = 1'b0;
        r.status   = swmc_pkg::ST_CANCELLED;
      end
      swmc_pkg::MODE_SAMPLE: begin
        if (kind < swmc_pkg::KIND_POWER && cap_active && ch == sel_channel &&
            kind == sel_kind && inp == sel_input) begin
          if (tag != 32'd0 && tag == last_tag) begin
            r.status = swmc_pkg::ST_DUPLICATE;
          end else begin
            last_tag = tag;
            if (discard_left > 0) begin
              discard_left--;
              r.status = swmc_pkg::ST_DISCARDED;
            end else begin
              if (code < win_min) win_min = code;
              if (code > win_max) win_max = code;
              win_sum += code;
              win_count++;
              if (win_count >= WIN) begin
                diff     = win_max - win_min;
                r.spread = diff[15:0];
                if (r.spread <= spread_setting) begin
                  // Round half away from zero; integer division truncates.
                  total = win_sum;
                  if (total >= 0) r.mean = 16'((total + WIN / 2) / WIN);
                  else r.mean = 16'((total - WIN / 2) / WIN);
                  cap_active = 1'b0;
                  r.status   = swmc_pkg::ST_CAPTURED;
                end else begin
                  restart_window();
                  r.status = swmc_pkg::ST_UNSTABLE;
                end
              end else begin
                r.status = swmc_pkg::ST_ACCUM;
              end
            end
          end
        end
      end
      default: r.status = swmc_pkg::ST_IGNORED;
    endcase
  endtask

  // Offer one input word after a random gap and record its expected result.
  task automatic send_word(input logic [1:0] mode, input logic [3:0] ch,
                           input logic [1:0] kind, input logic [3:0] inp,
                           input logic [31:0] tag, input logic signed [15:0] code);
    int gap;
    capture_result_t r;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {6'd0, code, tag, inp, kind, ch};
    do @(posedge clk); while (s_tready !== 1'b1);
    capture_step(mode, ch, kind, inp, tag, code, r);
    pending_results.push_back(r);
    items_sent++;
  endtask

  // A sample aimed at the configured target.
  task automatic send_target_sample(input logic [31:0] tag, input logic signed [15:0] code);
    send_word(swmc_pkg::MODE_SAMPLE, sel_channel, sel_kind, sel_input, tag, code);
  endtask

  // A word of the given mode with random content in every other field.
  task automatic send_mode_noise(input logic [1:0] mode);
    send_word(mode, 4'($urandom), 2'($urandom), 4'($urandom), $urandom, 16'($urandom));
  endtask

  // Hold off the sender until every expected result word has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, done only with nothing in flight.
  task automatic write_config(input logic [2:0] index, input logic [15:0] value);
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (index)
      swmc_pkg::REG_TARGET_CHANNEL: sel_channel     = value[3:0];
      swmc_pkg::REG_TARGET_KIND:    sel_kind        = value[1:0];
      swmc_pkg::REG_TARGET_INPUT:   sel_input       = value[3:0];
      swmc_pkg::REG_DISCARD_COUNT:  discard_setting = value[7:0];
      swmc_pkg::REG_SPREAD_LIMIT:   spread_setting  = value;
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Words while nothing is armed, straight out of reset.
  task automatic test_idle_items();
    send_target_sample(32'd7, swmc_pkg::CODE_MAX);
    send_mode_noise(swmc_pkg::MODE_CANCEL);
    send_mode_noise(MODE_RESERVED);
  endtask

  // Arm refusals, busy arm, and a bad target taking priority over busy.
  task automatic test_arm_checks();
    write_config(swmc_pkg::REG_TARGET_KIND, {14'd0, swmc_pkg::KIND_POWER});
    send_mode_noise(swmc_pkg::MODE_ARM);
    write_config(swmc_pkg::REG_TARGET_KIND, {14'd0, KIND_UNUSED});
    send_mode_noise(swmc_pkg::MODE_ARM);
    write_config(swmc_pkg::REG_TARGET_KIND, {14'd0, KIND_VOLTAGE});
    write_config(swmc_pkg::REG_TARGET_INPUT, 16'd0);
    send_mode_noise(swmc_pkg::MODE_ARM);
    write_config(swmc_pkg::REG_TARGET_INPUT, 16'd1);
    send_mode_noise(swmc_pkg::MODE_ARM);
    send_mode_noise(swmc_pkg::MODE_ARM);
    write_config(swmc_pkg::REG_TARGET_INPUT, 16'd0);
    send_mode_noise(swmc_pkg::MODE_ARM);
    write_config(swmc_pkg::REG_TARGET_INPUT, 16'd15);
    send_mode_noise(swmc_pkg::MODE_CANCEL);
  endtask

  // Target matching, duplicate tags, untagged words and the discard phase.
  task automatic test_sample_filter();
    write_config(swmc_pkg::REG_TARGET_CHANNEL, 16'd15);
    write_config(swmc_pkg::REG_TARGET_KIND, {14'd0, KIND_CURRENT});
    write_config(swmc_pkg::REG_DISCARD_COUNT, 16'd3);
    send_mode_noise(swmc_pkg::MODE_ARM);
    send_word(swmc_pkg::MODE_SAMPLE, sel_channel, swmc_pkg::KIND_POWER, sel_input, 32'd1,
              swmc_pkg::CODE_MAX);
    send_word(swmc_pkg::MODE_SAMPLE, sel_channel, KIND_UNUSED, sel_input, 32'd2,
              swmc_pkg::CODE_MIN);
    send_word(swmc_pkg::MODE_SAMPLE, 4'd0, sel_kind, sel_input, 32'd3, 16'sd0);
    send_word(swmc_pkg::MODE_SAMPLE, sel_channel, sel_kind, 4'd1, 32'd4, 16'sd0);
    send_word(swmc_pkg::MODE_SAMPLE, sel_channel, KIND_VOLTAGE, sel_input, 32'd5, 16'sd0);
    send_target_sample(32'd5, swmc_pkg::CODE_MAX);
    send_target_sample(32'd5, swmc_pkg::CODE_MAX);
    send_target_sample(32'd0, swmc_pkg::CODE_MIN);
    send_target_sample(32'd0, swmc_pkg::CODE_MIN);
    send_target_sample(32'hffff_ffff, swmc_pkg::CODE_MAX);
    send_target_sample(32'hffff_ffff, swmc_pkg::CODE_MIN);
    send_mode_noise(swmc_pkg::MODE_CANCEL);
  endtask

  // Random capture episodes: mostly well-formed runs with random content,
  // mixed with noise, stray arms, cancels and live limit changes.
  task automatic test_capture_runs();
    int episode;
    int flavor;
    int w;
    int c;
    int limit;
    int sent;
    int roll;
    bit flip;
    bit retarget;
    logic [31:0] prev_tag;
    logic [31:0] tag;
    logic signed [15:0] code;
    logic [15:0] spread_pick;
    episode    = 0;
    retarget   = 1'b1;
    prev_tag   = 32'd1;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      flavor  = $urandom_range(0, 5);
      w       = $urandom_range(0, 8);
      c       = int'($urandom_range(0, 65535 - 16)) - 32768;

      // Now and then an unusable target: refused arm, then ignored words.
      if (episode > 2 && $urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) == 0)
          write_config(swmc_pkg::REG_TARGET_KIND,
                       16'($urandom_range(swmc_pkg::KIND_POWER, KIND_UNUSED)));
        else
          write_config(swmc_pkg::REG_TARGET_INPUT, 16'd0);
        send_mode_noise(swmc_pkg::MODE_ARM);
        repeat ($urandom_range(1, 4)) send_target_sample($urandom, 16'($urandom));
        send_mode_noise(swmc_pkg::MODE_CANCEL);
        retarget = 1'b1;
      end

      // New target and discard length.
      if (retarget || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_config(swmc_pkg::REG_TARGET_CHANNEL, 16'd0);
          1:       write_config(swmc_pkg::REG_TARGET_CHANNEL, 16'd15);
          default: write_config(swmc_pkg::REG_TARGET_CHANNEL, 16'($urandom_range(0, 15)));
        endcase
        write_config(swmc_pkg::REG_TARGET_KIND,
                     16'($urandom_range(KIND_VOLTAGE, KIND_CURRENT)));
        case ($urandom_range(0, 3))
          0:       write_config(swmc_pkg::REG_TARGET_INPUT, 16'd1);
          1:       write_config(swmc_pkg::REG_TARGET_INPUT, 16'd15);
          default: write_config(swmc_pkg::REG_TARGET_INPUT, 16'($urandom_range(1, 15)));
        endcase
        if (episode == 2) write_config(swmc_pkg::REG_DISCARD_COUNT, 16'd255);
        else if ($urandom_range(0, 3) == 0) write_config(swmc_pkg::REG_DISCARD_COUNT, 16'd0);
        else write_config(swmc_pkg::REG_DISCARD_COUNT, 16'($urandom_range(1, 6)));
        retarget = 1'b0;
      end

      // Spread limit suited to the code pattern of this episode.
      roll = $urandom_range(0, 3);
      case (flavor)
        0: begin
          if (roll < 2) spread_pick = 16'($urandom_range(w, 64));
          else if (roll == 2) spread_pick = 16'($urandom_range(0, w));
          else spread_pick = 16'($urandom);
        end
        1:       spread_pick = (roll < 2) ? 16'hffff : 16'($urandom);
        4:       spread_pick = (roll < 2) ? 16'hffff : 16'hfffe;
        5:       spread_pick = (roll < 2) ? 16'd1 : ((roll == 2) ? 16'd0 : 16'($urandom));
        default: spread_pick = (roll < 2) ? 16'd0 : 16'($urandom);
      endcase
      write_config(swmc_pkg::REG_SPREAD_LIMIT, spread_pick);

      limit = discard_setting + 3 * WIN + 20;
      send_mode_noise(swmc_pkg::MODE_ARM);
      if ($urandom_range(0, 7) == 0) send_mode_noise(swmc_pkg::MODE_ARM);
      sent = 0;
      flip = 1'b0;
      while (cap_active && sent < limit) begin
        roll = $urandom_range(0, 999);
        if (roll < 800) begin
          // Matching sample; some repeat the previous tag, some are untagged.
          case ($urandom_range(0, 15))
            0:       tag = prev_tag;
            1:       tag = 32'd0;
            default: tag = $urandom;
          endcase
          case (flavor)
            0:       code = 16'(c + int'($urandom_range(0, w)));
            1:       code = 16'($urandom);
            2:       code = swmc_pkg::CODE_MAX;
            3:       code = swmc_pkg::CODE_MIN;
            4:       code = flip ? swmc_pkg::CODE_MAX : swmc_pkg::CODE_MIN;
            default: code = 16'(c + int'(flip));
          endcase
          flip = !flip;
          send_target_sample(tag, code);
          prev_tag = tag;
        end else if (roll < 900) begin
          send_mode_noise(swmc_pkg::MODE_SAMPLE);
        end else if (roll < 930) begin
          send_mode_noise(MODE_RESERVED);
        end else if (roll < 950) begin
          send_mode_noise(swmc_pkg::MODE_ARM);
        end else if (roll < 953) begin
          send_mode_noise(swmc_pkg::MODE_CANCEL);
        end else if (roll < 990) begin
          send_word(swmc_pkg::MODE_SAMPLE, sel_channel,
                    2'($urandom_range(swmc_pkg::KIND_POWER, KIND_UNUSED)),
                    sel_input, $urandom, 16'($urandom));
        end else begin
          // The limit is read live, so a change mid-capture applies at once.
          write_config(swmc_pkg::REG_SPREAD_LIMIT, 16'($urandom));
        end
        sent++;
      end
      if (cap_active) send_mode_noise(swmc_pkg::MODE_CANCEL);
      episode++;
    end
  endtask

  // Result side stalls a random number of cycles before each word.
  initial begin : result_sink
    int n;
    m_tready = 1'b0;
    forever begin
      n = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      repeat (n) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  initial begin : result_checker
    capture_result_t exp;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d", m_tuser);
          errors++;
        end else begin
          exp = pending_results.pop_front();
          words_checked++;
          status_count[m_tuser]++;
          if (m_tuser !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, m_tuser);
            errors++;
          end
          if (m_tdata[15:0] !== exp.mean) begin
            $error("mean_code: expected %0d, actual %0d", exp.mean, $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tdata[31:16] !== exp.spread) begin
            $error("window_spread: expected %0d, actual %0d", exp.spread, m_tdata[31:16]);
            errors++;
          end
        end
      end
    end
  end

  // End the run if no word of any channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : main
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = swmc_pkg::MODE_SAMPLE;
    cfg_valid = 1'b0;
    cfg_index = swmc_pkg::REG_TARGET_CHANNEL;
    cfg_data  = '0;
    tx_gaps   = 1'b1;
    rx_gaps   = 1'b1;

    // Register defaults and idle capture state after reset.
    sel_channel     = 4'd0;
    sel_kind        = KIND_VOLTAGE;
    sel_input       = 4'd1;
    discard_setting = 8'd4;
    spread_setting  = 16'd8;
    cap_active      = 1'b0;
    discard_left    = '0;
    win_count       = '0;
    win_min         = swmc_pkg::CODE_MAX;
    win_max         = swmc_pkg::CODE_MIN;
    win_sum         = '0;
    last_tag        = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_items();
    test_arm_checks();
    test_sample_filter();
    test_capture_runs();

    // Let the last words come back, then watch for strays.
    wait_results_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      errors++;
    end

    $display("summary: %0d result words checked, %0d config writes, %0d mismatches",
             words_checked, config_writes, errors);
    $display("summary: %0d captures, %0d unstable restarts, %0d duplicates, %0d busy, %0d bad",
             status_count[swmc_pkg::ST_CAPTURED], status_count[swmc_pkg::ST_UNSTABLE],
             status_count[swmc_pkg::ST_DUPLICATE], status_count[swmc_pkg::ST_BUSY],
             status_count[swmc_pkg::ST_INVALID]);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/swmc_pkg.sv
sv/swmc_front.sv
sv/swmc_queue.sv
sv/swmc_back.sv
sv/stable_window_mean_capture.sv
tb/testbench.sv
